// ===== rtl/uvs_pkg.sv =====
package uvs_pkg;

    // register indexes of the configuration port
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SECTORS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STACKS  = 2'd2;

    localparam int RADIUS_W = 16;
    localparam int COUNT_W  = 11;
    localparam int POS_W    = 17;
    localparam int NORM_W   = 16;
    localparam int TEX_W    = 17;
    localparam int TEX_FRAC = 16;

    localparam logic [RADIUS_W-1:0] RADIUS_RST  = 16'd256;
    localparam logic [COUNT_W-1:0]  SECTORS_RST = 11'd16;
    localparam logic [COUNT_W-1:0]  STACKS_RST  = 11'd8;

    // q30 sine fraction and polynomial coefficients
    localparam int XW = 31;
    localparam logic [XW-1:0] ONE_Q30 = 31'd1073741824;
    localparam logic [XW-1:0] K9 = 31'd172272;
    localparam logic [XW-1:0] HORNER_K [4] = '{31'd5026996, 31'd85569306,
                                               31'd693598669, 31'd1686629713};
    localparam logic [16:0] SINE_CAP = 17'd16384;

    // product shifted right by 14, rounded half away from zero
    function automatic logic signed [19:0] rnd14(input logic signed [33:0] p);
        logic [33:0] m;
        logic [19:0] q;
        m = p[33] ? 34'(-p) : 34'(p);
        m = m + 34'd8192;
        q = 20'(m >> 14);
        return p[33] ? -$signed(q) : $signed(q);
    endfunction

endpackage

// ===== rtl/uvs_req_if.sv =====
interface uvs_req_if;
    logic        valid;
    logic        ready;
    logic [10:0] stack_index;
    logic [10:0] sector_index;

    modport source (output valid, output stack_index, output sector_index, input ready);
    modport sink   (input valid, input stack_index, input sector_index, output ready);
endinterface

// ===== rtl/uvs_vtx_if.sv =====
interface uvs_vtx_if;
    logic               valid;
    logic               ready;
    logic signed [16:0] pos_x;
    logic signed [16:0] pos_y;
    logic signed [16:0] pos_z;
    logic signed [15:0] norm_x;
    logic signed [15:0] norm_y;
    logic signed [15:0] norm_z;
    logic [16:0]        tex_u;
    logic [16:0]        tex_v;

    modport source (output valid, output pos_x, output pos_y, output pos_z, output norm_x,
                    output norm_y, output norm_z, output tex_u, output tex_v, input ready);
    modport sink   (input valid, input pos_x, input pos_y, input pos_z, input norm_x,
                    input norm_y, input norm_z, input tex_u, input tex_v, output ready);
endinterface

// ===== rtl/uvs_div_cell.sv =====
// one restoring division step: one quotient bit per cell
module uvs_div_cell #(
    parameter int DW = 28
) (
    input  logic                        clk,
    input  logic                        en,
    input  logic [uvs_pkg::COUNT_W-1:0] divisor,
    input  logic [uvs_pkg::COUNT_W-1:0] rem_in,
    input  logic [DW-1:0]               dvd_in,
    input  logic [DW-1:0]               quot_in,
    output logic [uvs_pkg::COUNT_W-1:0] rem_out,
    output logic [DW-1:0]               dvd_out,
    output logic [DW-1:0]               quot_out
);
    logic [uvs_pkg::COUNT_W:0]   trial;
    logic                        ge;
    logic [uvs_pkg::COUNT_W-1:0] rem_next;
    logic [uvs_pkg::COUNT_W-1:0] rem_reg;
    logic [DW-1:0]               dvd_reg;
    logic [DW-1:0]               quot_reg;

    always_comb
    begin
        trial    = {rem_in, dvd_in[DW-1]};
        ge       = trial >= {1'b0, divisor};
        rem_next = ge ? uvs_pkg::COUNT_W'(trial - {1'b0, divisor})
                      : trial[uvs_pkg::COUNT_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            dvd_reg  <= {dvd_in[DW-2:0], 1'b0};
            quot_reg <= {quot_in[DW-2:0], ge};
        end
    end

    assign rem_out  = rem_reg;
    assign dvd_out  = dvd_reg;
    assign quot_out = quot_reg;
endmodule

// ===== rtl/uvs_poly_cell.sv =====
// one horner step of the sine polynomial: t = k - (x2 * t) >> 30
module uvs_poly_cell (
    input  logic                   clk,
    input  logic                   en,
    input  logic [uvs_pkg::XW-1:0] coef,
    input  logic [uvs_pkg::XW-1:0] x_in,
    input  logic [uvs_pkg::XW-1:0] x2_in,
    input  logic [uvs_pkg::XW-1:0] t_in,
    input  logic                   neg_in,
    output logic [uvs_pkg::XW-1:0] x_out,
    output logic [uvs_pkg::XW-1:0] x2_out,
    output logic [uvs_pkg::XW-1:0] t_out,
    output logic                   neg_out
);
    logic [2*uvs_pkg::XW-1:0] prod;
    logic [uvs_pkg::XW-1:0]   t_next;
    logic [uvs_pkg::XW-1:0]   x_reg;
    logic [uvs_pkg::XW-1:0]   x2_reg;
    logic [uvs_pkg::XW-1:0]   t_reg;
    logic                     neg_reg;

    always_comb
    begin
        prod   = (2*uvs_pkg::XW)'(x2_in) * (2*uvs_pkg::XW)'(t_in);
        t_next = coef - prod[60:30];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg   <= x_in;
            x2_reg  <= x2_in;
            t_reg   <= t_next;
            neg_reg <= neg_in;
        end
    end

    assign x_out   = x_reg;
    assign x2_out  = x2_reg;
    assign t_out   = t_reg;
    assign neg_out = neg_reg;
endmodule

// ===== rtl/uv_sphere_vertex_gen_unit.sv =====
// uv sphere vertex generator: each request (stack_index, sector_index) yields one vertex
// with a q8.8 position scaled by radius, a q1.14 normal and texture coordinates where
// 65536 is 1.0. the unit takes one request per clock while the pipeline is not backed up
// and returns results in order. a row of division cells (one quotient bit each) turns the
// indices into angle phases and texture coordinates, followed by the sine polynomial cells
// and two multiply stages. every stage holds its request only while the next is full, so
// bubbles close up and new requests are taken while a finished vertex waits. the user
// must write configuration registers only while the unit is empty; the unit does not
// enforce this. counts of zero act as one, counts above MAX_DIVISIONS act as
// MAX_DIVISIONS, and indices above the counts are clamped to them.
module uv_sphere_vertex_gen_unit #(
    parameter int MAX_DIVISIONS = 1024,
    parameter int ANGLE_BITS    = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [uvs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [uvs_pkg::RADIUS_W-1:0]   cfg_data,
    uvs_req_if.sink                        req,
    uvs_vtx_if.source                      vtx
);
    localparam int A       = ANGLE_BITS;
    localparam int CW      = uvs_pkg::COUNT_W;
    localparam int FMAX    = (A > uvs_pkg::TEX_FRAC) ? A : uvs_pkg::TEX_FRAC;
    localparam int DW      = CW + 1 + FMAX;
    localparam int MAXC    = (MAX_DIVISIONS > 2047) ? 2047 : MAX_DIVISIONS;
    // stage map
    localparam int ST_DIV0 = 1;
    localparam int ST_FOLD = DW + 1;
    localparam int ST_SQ   = DW + 2;
    localparam int ST_H0   = DW + 3;
    localparam int ST_SIN1 = DW + 7;
    localparam int ST_SIN2 = DW + 8;
    localparam int ST_M1   = DW + 9;
    localparam int ST_M2   = DW + 10;
    localparam int NST     = DW + 11;
    localparam int NPOST   = NST - ST_FOLD;
    localparam int XW      = uvs_pkg::XW;

    // configuration registers
    logic [uvs_pkg::RADIUS_W-1:0] radius_reg;
    logic [CW-1:0]                sectors_reg;
    logic [CW-1:0]                stacks_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg  <= uvs_pkg::RADIUS_RST;
            sectors_reg <= uvs_pkg::SECTORS_RST;
            stacks_reg  <= uvs_pkg::STACKS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                uvs_pkg::CFG_RADIUS:  radius_reg  <= cfg_data;
                uvs_pkg::CFG_SECTORS: sectors_reg <= CW'(cfg_data);
                uvs_pkg::CFG_STACKS:  stacks_reg  <= CW'(cfg_data);
                default:              ;
            endcase
        end
    end

    // effective counts; the user must keep them stable while any request is in flight, the unit does not enforce it
    logic [CW-1:0] secs;
    logic [CW-1:0] stks;

    always_comb
    begin
        secs = (sectors_reg == '0) ? CW'(1)
             : ((int'(sectors_reg) > MAXC) ? CW'(MAXC) : sectors_reg);
        stks = (stacks_reg == '0) ? CW'(1)
             : ((int'(stacks_reg) > MAXC) ? CW'(MAXC) : stacks_reg);
    end

    // stage handshake: a stage loads when it is empty or its content moves on
    logic [NST-1:0] valid_reg;
    logic [NST-1:0] valid_next;
    logic [NST:0]   rdy;

    always_comb
    begin
        rdy[NST] = vtx.ready;
        for (int k = NST - 1; k >= 0; k--)
        begin
            rdy[k] = !valid_reg[k] || rdy[k+1];
        end
        for (int k = 0; k < NST; k++)
        begin
            if (rdy[k])
            begin
                valid_next[k] = (k == 0) ? req.valid : valid_reg[(k == 0) ? 0 : k - 1];
            end
            else
            begin
                valid_next[k] = valid_reg[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign req.ready = rdy[0];

    // input stage: clamp and build dividends for the four division lanes
    // lane 0: v phase, lane 1: u offset, lane 2: tex_u, lane 3: tex_v
    logic [CW-1:0] i_cl;
    logic [CW-1:0] j_cl;
    logic [DW-1:0] dvd_next [4];
    logic [DW-1:0] dvd0_reg [4];
    logic [CW-1:0] lane_div [4];

    always_comb
    begin
        i_cl = (req.stack_index > stks) ? stks : req.stack_index;
        j_cl = (req.sector_index > secs) ? secs : req.sector_index;
        dvd_next[0] = (DW'(j_cl) << A) + DW'(secs >> 1);
        dvd_next[1] = (DW'(i_cl) << (A - 1)) + DW'(stks >> 1);
        dvd_next[2] = (DW'(j_cl) << uvs_pkg::TEX_FRAC) + DW'(secs >> 1);
        dvd_next[3] = (DW'(i_cl) << uvs_pkg::TEX_FRAC) + DW'(stks >> 1);
        lane_div[0] = secs;
        lane_div[1] = stks;
        lane_div[2] = secs;
        lane_div[3] = stks;
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            dvd0_reg <= dvd_next;
        end
    end

    // division row
    logic [CW-1:0] rem_w  [4][DW+1];
    logic [DW-1:0] dvd_w  [4][DW+1];
    logic [DW-1:0] quot_w [4][DW+1];

    for (genvar ln = 0; ln < 4; ln++)
    begin : g_lane
        assign rem_w[ln][0]  = '0;
        assign dvd_w[ln][0]  = dvd0_reg[ln];
        assign quot_w[ln][0] = '0;
        for (genvar s = 0; s < DW; s++)
        begin : g_step
            uvs_div_cell #(.DW(DW)) u_cell (
                .clk      (clk),
                .en       (rdy[ST_DIV0 + s]),
                .divisor  (lane_div[ln]),
                .rem_in   (rem_w[ln][s]),
                .dvd_in   (dvd_w[ln][s]),
                .quot_in  (quot_w[ln][s]),
                .rem_out  (rem_w[ln][s+1]),
                .dvd_out  (dvd_w[ln][s+1]),
                .quot_out (quot_w[ln][s+1])
            );
        end
    end

    // texture coordinates ride along the remaining stages
    logic [uvs_pkg::TEX_W-1:0] tex_u_reg [NPOST];
    logic [uvs_pkg::TEX_W-1:0] tex_v_reg [NPOST];

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NPOST; k++)
        begin
            if (rdy[ST_FOLD + k])
            begin
                tex_u_reg[k] <= (k == 0) ? quot_w[2][DW][uvs_pkg::TEX_W-1:0]
                                         : tex_u_reg[(k == 0) ? 0 : k - 1];
                tex_v_reg[k] <= (k == 0) ? quot_w[3][DW][uvs_pkg::TEX_W-1:0]
                                         : tex_v_reg[(k == 0) ? 0 : k - 1];
            end
        end
    end

    // fold stage: phases to a quarter-turn fraction and a sign
    // sine lanes: 0 sin u, 1 cos u, 2 sin v, 3 cos v
    logic [A-1:0]  uph;
    logic [A-1:0]  vph;
    logic [A-1:0]  ph [4];
    logic [XW-1:0] x_next [4];
    logic [XW-1:0] xf_reg [4];
    logic [3:0]    negf_reg;
    logic [3:0]    neg_next;

    always_comb
    begin
        vph   = quot_w[0][DW][A-1:0];
        uph   = A'(1 << (A - 2)) - quot_w[1][DW][A-1:0];
        ph[0] = uph;
        ph[1] = uph + A'(1 << (A - 2));
        ph[2] = vph;
        ph[3] = vph + A'(1 << (A - 2));
        for (int ln = 0; ln < 4; ln++)
        begin
            x_next[ln]   = {1'b0, ph[ln][A-3:0], (32 - A)'(0)};
            if (ph[ln][A-2])
            begin
                x_next[ln] = uvs_pkg::ONE_Q30 - x_next[ln];
            end
            neg_next[ln] = ph[ln][A-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[ST_FOLD])
        begin
            xf_reg   <= x_next;
            negf_reg <= neg_next;
        end
    end

    // square stage
    logic [2*XW-1:0] sq [4];
    logic [XW-1:0]   xs_reg  [4];
    logic [XW-1:0]   x2s_reg [4];
    logic [3:0]      negs_reg;

    always_comb
    begin
        for (int ln = 0; ln < 4; ln++)
        begin
            sq[ln] = (2*XW)'(xf_reg[ln]) * (2*XW)'(xf_reg[ln]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[ST_SQ])
        begin
            xs_reg   <= xf_reg;
            negs_reg <= negf_reg;
            for (int ln = 0; ln < 4; ln++)
            begin
                x2s_reg[ln] <= sq[ln][60:30];
            end
        end
    end

    // horner row
    logic [XW-1:0] hx  [4][5];
    logic [XW-1:0] hx2 [4][5];
    logic [XW-1:0] ht  [4][5];
    logic          hn  [4][5];

    for (genvar ln = 0; ln < 4; ln++)
    begin : g_sine
        assign hx[ln][0]  = xs_reg[ln];
        assign hx2[ln][0] = x2s_reg[ln];
        assign ht[ln][0]  = uvs_pkg::K9;
        assign hn[ln][0]  = negs_reg[ln];
        for (genvar h = 0; h < 4; h++)
        begin : g_step
            uvs_poly_cell u_cell (
                .clk     (clk),
                .en      (rdy[ST_H0 + h]),
                .coef    (uvs_pkg::HORNER_K[h]),
                .x_in    (hx[ln][h]),
                .x2_in   (hx2[ln][h]),
                .t_in    (ht[ln][h]),
                .neg_in  (hn[ln][h]),
                .x_out   (hx[ln][h+1]),
                .x2_out  (hx2[ln][h+1]),
                .t_out   (ht[ln][h+1]),
                .neg_out (hn[ln][h+1])
            );
        end
    end

    // final multiply of the polynomial, then round to q1.14
    logic [2*XW-1:0] xt [4];
    logic [31:0]     r_reg [4];
    logic [3:0]      negr_reg;
    logic [32:0]     rs [4];
    logic [16:0]     mag [4];
    logic signed [uvs_pkg::NORM_W-1:0] s_next [4];
    logic signed [uvs_pkg::NORM_W-1:0] s_reg  [4];

    always_comb
    begin
        for (int ln = 0; ln < 4; ln++)
        begin
            xt[ln]  = (2*XW)'(hx[ln][4]) * (2*XW)'(ht[ln][4]);
            rs[ln]  = 33'(r_reg[ln]) + 33'd32768;
            mag[ln] = rs[ln][32:16];
            if (mag[ln] > uvs_pkg::SINE_CAP)
            begin
                mag[ln] = uvs_pkg::SINE_CAP;
            end
            s_next[ln] = negr_reg[ln] ? -$signed(uvs_pkg::NORM_W'(mag[ln]))
                                      : $signed(uvs_pkg::NORM_W'(mag[ln]));
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[ST_SIN1])
        begin
            for (int ln = 0; ln < 4; ln++)
            begin
                r_reg[ln]    <= xt[ln][61:30];
                negr_reg[ln] <= hn[ln][4];
            end
        end
        if (rdy[ST_SIN2])
        begin
            s_reg <= s_next;
        end
    end

    // first product stage
    logic signed [16:0] rad_s;
    logic signed [16:0] xy_reg;
    logic signed [16:0] pz_reg;
    logic signed [15:0] nx_reg;
    logic signed [15:0] ny_reg;
    logic signed [15:0] nz_reg;
    logic signed [15:0] sv_reg;
    logic signed [15:0] cv_reg;
    logic signed [19:0] xy_next;
    logic signed [19:0] pz_next;
    logic signed [19:0] nx_next;
    logic signed [19:0] ny_next;

    always_comb
    begin
        rad_s   = $signed({1'b0, radius_reg});
        xy_next = uvs_pkg::rnd14(34'(rad_s) * 34'(s_reg[1]));
        pz_next = uvs_pkg::rnd14(34'(rad_s) * 34'(s_reg[0]));
        nx_next = uvs_pkg::rnd14(34'(s_reg[1]) * 34'(s_reg[3]));
        ny_next = uvs_pkg::rnd14(34'(s_reg[1]) * 34'(s_reg[2]));
    end

    always_ff @(posedge clk)
    begin
        if (rdy[ST_M1])
        begin
            xy_reg <= xy_next[16:0];
            pz_reg <= pz_next[16:0];
            nx_reg <= nx_next[15:0];
            ny_reg <= ny_next[15:0];
            nz_reg <= s_reg[0];
            sv_reg <= s_reg[2];
            cv_reg <= s_reg[3];
        end
    end

    // output stage
    logic signed [19:0] px_next;
    logic signed [19:0] py_next;
    logic signed [16:0] px_reg;
    logic signed [16:0] py_reg;
    logic signed [16:0] pz_out_reg;
    logic signed [15:0] nx_out_reg;
    logic signed [15:0] ny_out_reg;
    logic signed [15:0] nz_out_reg;

    always_comb
    begin
        px_next = uvs_pkg::rnd14(34'(xy_reg) * 34'(cv_reg));
        py_next = uvs_pkg::rnd14(34'(xy_reg) * 34'(sv_reg));
    end

    always_ff @(posedge clk)
    begin
        if (rdy[ST_M2])
        begin
            px_reg     <= px_next[16:0];
            py_reg     <= py_next[16:0];
            pz_out_reg <= pz_reg;
            nx_out_reg <= nx_reg;
            ny_out_reg <= ny_reg;
            nz_out_reg <= nz_reg;
        end
    end

    assign vtx.valid  = valid_reg[NST-1];
    assign vtx.pos_x  = px_reg;
    assign vtx.pos_y  = py_reg;
    assign vtx.pos_z  = pz_out_reg;
    assign vtx.norm_x = nx_out_reg;
    assign vtx.norm_y = ny_out_reg;
    assign vtx.norm_z = nz_out_reg;
    assign vtx.tex_u  = tex_u_reg[NPOST-1];
    assign vtx.tex_v  = tex_v_reg[NPOST-1];

    // an empty pipeline always takes a request
    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg == '0 |-> req.ready)
        else $error("empty pipeline refused a request");

    // the normal z component stays within one in q1.14
    a_norm_range: assert property (@(posedge clk) disable iff (!rst_n)
        vtx.valid |-> (vtx.norm_z <= 16'sd16384 && vtx.norm_z >= -16'sd16384))
        else $error("normal out of range");

    // texture coordinates never pass 1.0
    a_tex_range: assert property (@(posedge clk) disable iff (!rst_n)
        vtx.valid |-> (vtx.tex_u <= 17'd65536 && vtx.tex_v <= 17'd65536))
        else $error("texture coordinate out of range");
endmodule

// ===== tb/sv/uv_sphere_vertex_gen_unit_tb.sv =====
`timescale 1ns / 1ps

module uv_sphere_vertex_gen_unit_tb;

    // expected vertex fields
    typedef struct packed {
        logic signed [uvs_pkg::POS_W-1:0]  pos_x;
        logic signed [uvs_pkg::POS_W-1:0]  pos_y;
        logic signed [uvs_pkg::POS_W-1:0]  pos_z;
        logic signed [uvs_pkg::NORM_W-1:0] norm_x;
        logic signed [uvs_pkg::NORM_W-1:0] norm_y;
        logic signed [uvs_pkg::NORM_W-1:0] norm_z;
        logic [uvs_pkg::TEX_W-1:0]         tex_u;
        logic [uvs_pkg::TEX_W-1:0]         tex_v;
    } vertex_t;

    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 60;

    // scoreboard: holds the vertices still owed by the unit
    class vertex_scoreboard;
        logic [uvs_pkg::RADIUS_W-1:0] radius;
        logic [uvs_pkg::COUNT_W-1:0]  sectors;
        logic [uvs_pkg::COUNT_W-1:0]  stacks;
        vertex_t                      pending[$];
        int                           errors;

        function new();
            radius  = uvs_pkg::RADIUS_RST;
            sectors = uvs_pkg::SECTORS_RST;
            stacks  = uvs_pkg::STACKS_RST;
            errors  = 0;
        endfunction

        function longint clamp_count(longint c);
            if (c == 0) return 1;
            if (c > 1024) return 1024;
            return c;
        endfunction

        // sin(pi x / 2), x in q30, result q1.14
        function longint quarter_sin(longint x);
            longint x2;
            longint t;
            longint r;
            x2 = (x * x) >>> 30;
            t = 172272;
            t = 5026996 - ((x2 * t) >>> 30);
            t = 85569306 - ((x2 * t) >>> 30);
            t = 693598669 - ((x2 * t) >>> 30);
            t = 1686629713 - ((x2 * t) >>> 30);
            r = (x * t) >>> 30;
            r = (r + 32768) >>> 16;
            if (r > 16384) r = 16384;
            return r;
        endfunction

        function longint sin_q14(longint phase);
            longint p;
            longint x;
            longint s;
            p = phase & 16'hFFFF;
            x = (p & 16'h3FFF) << 16;
            if (p[14]) x = 64'd1073741824 - x;
            s = quarter_sin(x);
            return p[15] ? -s : s;
        endfunction

        function longint mul_round14(longint a, longint b);
            longint v;
            longint m;
            v = a * b;
            m = (v < 0) ? -v : v;
            m = (m + 8192) >>> 14;
            return (v < 0) ? -m : m;
        endfunction

        function void write_reg(logic [uvs_pkg::CFG_IDX_W-1:0] idx,
                                logic [uvs_pkg::RADIUS_W-1:0] d);
            if (idx == uvs_pkg::CFG_RADIUS) radius = d;
            else if (idx == uvs_pkg::CFG_SECTORS) sectors = d[uvs_pkg::COUNT_W-1:0];
            else if (idx == uvs_pkg::CFG_STACKS) stacks = d[uvs_pkg::COUNT_W-1:0];
        endfunction

        function void note_request(logic [10:0] stack_i, logic [10:0] sector_j);
            longint secs, stks, i, j, vph, uph, su, cu, sv, cv, xy;
            vertex_t e;
            secs = clamp_count(sectors);
            stks = clamp_count(stacks);
            i = stack_i;
            j = sector_j;
            if (i > stks) i = stks;
            if (j > secs) j = secs;
            vph = (((j << 16) + secs / 2) / secs) & 16'hFFFF;
            uph = (16384 - (((i << 15) + stks / 2) / stks)) & 16'hFFFF;
            su = sin_q14(uph);
            cu = sin_q14(uph + 16384);
            sv = sin_q14(vph);
            cv = sin_q14(vph + 16384);
            xy = mul_round14(radius, cu);
            e.pos_x  = uvs_pkg::POS_W'(mul_round14(xy, cv));
            e.pos_y  = uvs_pkg::POS_W'(mul_round14(xy, sv));
            e.pos_z  = uvs_pkg::POS_W'(mul_round14(radius, su));
            e.norm_x = uvs_pkg::NORM_W'(mul_round14(cu, cv));
            e.norm_y = uvs_pkg::NORM_W'(mul_round14(cu, sv));
            e.norm_z = uvs_pkg::NORM_W'(su);
            e.tex_u  = uvs_pkg::TEX_W'(((j << 16) + secs / 2) / secs);
            e.tex_v  = uvs_pkg::TEX_W'(((i << 16) + stks / 2) / stks);
            pending.insert(pending.size(), e);
        endfunction

        function void check_vertex(vertex_t a);
            vertex_t e;
            if (pending.size() == 0)
            begin
                $error("vertex with no request outstanding");
                errors++;
                return;
            end
            e = pending.pop_front();
            if (a.pos_x !== e.pos_x)
            begin
                $error("pos_x exp %0d got %0d", e.pos_x, a.pos_x); errors++;
            end
            if (a.pos_y !== e.pos_y)
            begin
                $error("pos_y exp %0d got %0d", e.pos_y, a.pos_y); errors++;
            end
            if (a.pos_z !== e.pos_z)
            begin
                $error("pos_z exp %0d got %0d", e.pos_z, a.pos_z); errors++;
            end
            if (a.norm_x !== e.norm_x)
            begin
                $error("norm_x exp %0d got %0d", e.norm_x, a.norm_x); errors++;
            end
            if (a.norm_y !== e.norm_y)
            begin
                $error("norm_y exp %0d got %0d", e.norm_y, a.norm_y); errors++;
            end
            if (a.norm_z !== e.norm_z)
            begin
                $error("norm_z exp %0d got %0d", e.norm_z, a.norm_z); errors++;
            end
            if (a.tex_u !== e.tex_u)
            begin
                $error("tex_u exp %0d got %0d", e.tex_u, a.tex_u); errors++;
            end
            if (a.tex_v !== e.tex_v)
            begin
                $error("tex_v exp %0d got %0d", e.tex_v, a.tex_v); errors++;
            end
        endfunction
    endclass

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_we;
    logic [uvs_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [uvs_pkg::RADIUS_W-1:0]   cfg_data;
    longint                         cycle_count;
    logic                           hold_off;
    logic                           burst_phase;
    vertex_scoreboard               vertex_sb;

    uvs_req_if req ();
    uvs_vtx_if vtx ();

    uv_sphere_vertex_gen_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req.sink),
        .vtx       (vtx.source)
    );

    // 20 ns clock
    initial clk = 1'b0;
    always #10 clk = ~clk;

    // cycle counter doubles as the run watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("uv_sphere_vertex_gen_unit_tb failed");
            $finish;
        end
    end

    // monitor: every accepted vertex goes to the scoreboard
    always @(posedge clk)
    begin
        if (rst_n && vtx.valid && vtx.ready)
            vertex_sb.check_vertex('{vtx.pos_x, vtx.pos_y, vtx.pos_z, vtx.norm_x,
                                     vtx.norm_y, vtx.norm_z, vtx.tex_u, vtx.tex_v});
    end

    // receiver: random stalls, plus a long hold-off while hold_off is set
    initial
    begin
        int gap;
        vtx.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off)
            begin
                vtx.ready <= 1'b0;
            end
            else if (vtx.ready && vtx.valid || !vtx.ready)
            begin
                gap = $urandom_range(0, 3);
                // no-stall stretches every so often
                if ($urandom_range(0, 3) == 0) gap = 0;
                if (gap == 0)
                begin
                    vtx.ready <= 1'b1;
                end
                else
                begin
                    vtx.ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                    vtx.ready <= 1'b1;
                end
            end
        end
    end

    // long receiver hold-off while requests keep coming, so the pipeline backs up
    initial
    begin
        hold_off = 1'b0;
        wait (burst_phase);
        repeat (20) @(posedge clk);
        hold_off <= 1'b1;
        repeat (200) @(posedge clk);
        hold_off <= 1'b0;
    end

    // send one request, waiting for it to be taken
    task automatic send_request(logic [10:0] stack_i, logic [10:0] sector_j);
        int gap;
        gap = $urandom_range(0, 3);
        if ($urandom_range(0, 2) == 0) gap = 0;
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid        <= 1'b1;
        req.stack_index  <= stack_i;
        req.sector_index <= sector_j;
        @(posedge clk);
        while (!req.ready) @(posedge clk);
        vertex_sb.note_request(stack_i, sector_j);
    endtask

    // let the unit empty out before touching registers
    task automatic wait_idle();
        req.valid <= 1'b0;
        @(posedge clk);
        while (vertex_sb.pending.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [uvs_pkg::CFG_IDX_W-1:0] idx,
                             logic [uvs_pkg::RADIUS_W-1:0] d);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
        cfg_we    <= 1'b0;
        vertex_sb.write_reg(idx, d);
        @(posedge clk);
    endtask

    // mostly in-range grid points, sometimes beyond the counts or any 11-bit value
    task automatic random_requests(int n);
        logic [10:0] si;
        logic [10:0] sj;
        int          stks;
        int          secs;
        for (int k = 0; k < n; k++)
        begin
            stks = (vertex_sb.stacks == 0) ? 1 : int'(vertex_sb.stacks);
            secs = (vertex_sb.sectors == 0) ? 1 : int'(vertex_sb.sectors);
            case ($urandom_range(0, 9))
                0:
                begin
                    si = 11'($urandom);
                    sj = 11'($urandom);
                end
                1:
                begin
                    si = (stks > 1024) ? 11'd1024 : 11'(stks);
                    sj = 11'($urandom_range(0, 2047));
                end
                default:
                begin
                    si = 11'($urandom_range(0, (stks > 1024) ? 1024 : stks));
                    sj = 11'($urandom_range(0, (secs > 1024) ? 1024 : secs));
                end
            endcase
            send_request(si, sj);
        end
    endtask

    initial
    begin
        logic [uvs_pkg::RADIUS_W-1:0] radii [6];
        logic [uvs_pkg::COUNT_W-1:0]  secs_set [6];
        logic [uvs_pkg::COUNT_W-1:0]  stks_set [6];
        radii    = '{16'hFFFF, 16'd0, 16'd1, 16'd12345, 16'h8000, 16'd256};
        secs_set = '{11'd1024, 11'd1, 11'd0, 11'd2047, 11'd37, 11'd1025};
        stks_set = '{11'd1, 11'd1024, 11'd2047, 11'd0, 11'd13, 11'd5};
        vertex_sb        = new();
        cycle_count      = 0;
        burst_phase      = 1'b0;
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = uvs_pkg::CFG_RADIUS;
        cfg_data         = '0;
        req.valid        = 1'b0;
        req.stack_index  = '0;
        req.sector_index = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset settings, poles, seam, index clamp, field extremes
        send_request(11'd0, 11'd0);
        send_request(11'd8, 11'd16);
        send_request(11'd4, 11'd4);
        send_request(11'd2047, 11'd2047);
        send_request(11'd1024, 11'd1024);
        send_request(11'd1, 11'd15);
        send_request(11'h555, 11'h2AA);
        send_request(11'h2AA, 11'h555);
        send_request(11'd7, 11'd9);
        wait_idle();

        // zero radius, tiny counts
        write_reg(uvs_pkg::CFG_RADIUS, 16'd0);
        write_reg(uvs_pkg::CFG_SECTORS, 16'd0);
        write_reg(uvs_pkg::CFG_STACKS, 16'd1);
        send_request(11'd0, 11'd0);
        send_request(11'd1, 11'd1);
        send_request(11'd2047, 11'd2047);
        wait_idle();

        // largest radius and counts, above-range counts too
        write_reg(uvs_pkg::CFG_RADIUS, 16'hFFFF);
        write_reg(uvs_pkg::CFG_SECTORS, 16'd1024);
        write_reg(uvs_pkg::CFG_STACKS, 16'd2047);
        send_request(11'd512, 11'd0);
        send_request(11'd0, 11'd256);
        send_request(11'd1024, 11'd768);
        send_request(11'd300, 11'd1023);
        send_request(11'd2047, 11'd1024);
        wait_idle();

        // random phases over a spread of settings
        burst_phase = 1'b1;
        for (int s = 0; s < 6; s++)
        begin
            write_reg(uvs_pkg::CFG_RADIUS, radii[s]);
            write_reg(uvs_pkg::CFG_SECTORS, {5'd0, secs_set[s]});
            write_reg(uvs_pkg::CFG_STACKS, {5'd0, stks_set[s]});
            random_requests(150);
            wait_idle();
        end

        if (vertex_sb.errors == 0)
            $display("uv_sphere_vertex_gen_unit_tb passed");
        else
            $display("uv_sphere_vertex_gen_unit_tb failed");
        $finish;
    end

endmodule
